// ===== rtl/dpmn_pkg.sv =====
// ----------------------------------------------------------------------------
// DisplayPort M/N calculator package
// Shared widths, constants, sequencer states and unit status types.
// ----------------------------------------------------------------------------
package dpmn_pkg;

  // Widths of the request fields.
  localparam int PCLK_W  = 21;
  localparam int LRATE_W = 20;
  localparam int LANES_W = 3;
  localparam int BPP_W   = 6;

  // Width of every result field.
  localparam int FIELD_W = 24;

  // Stream clock (10 * pixel clock) and link clock (10 * link rate) widths.
  localparam int STRM_W = 25;
  localparam int LCLK_W = 24;

  // Bits per pixel times the stream clock, and link clock * lanes * 8.
  localparam int PROD_W = 31;
  localparam int DEN_W  = 30;

  // Dividend of the shared divider for the data pair: the data product times 2^27.
  localparam int DATA_N_SHIFT = 27;
  localparam int LINK_N_SHIFT = 19;
  localparam int NUM_W        = PROD_W + DATA_N_SHIFT;

  // Width of the N value before normalization.
  localparam int N_W = DATA_N_SHIFT + 1;

  // Iteration counter of the divider, one quotient bit per cycle.
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic [N_W-1:0]    DATA_N_BASE = N_W'(1) << DATA_N_SHIFT;
  localparam logic [N_W-1:0]    LINK_N_BASE = N_W'(1) << LINK_N_SHIFT;
  localparam logic [STRM_W-1:0] CLOCK_SCALE = STRM_W'(10);

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_LOAD_DD,
    ST_WAIT_DD,
    ST_LOAD_ND,
    ST_WAIT_ND,
    ST_LOAD_DL,
    ST_WAIT_DL,
    ST_LOAD_NL,
    ST_WAIT_NL,
    ST_DONE
  } state_t;

  // Status of an iterative unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== rtl/dpmn_mode_if.sv =====
// ----------------------------------------------------------------------------
// DisplayPort M/N calculator mode channel
// Carries one mode request: pixel clock, link rate, lanes and bits per pixel.
// ----------------------------------------------------------------------------
interface dpmn_mode_if;

  logic                          valid;
  logic                          ready;
  logic [dpmn_pkg::PCLK_W-1:0]   pix_clk;
  logic [dpmn_pkg::LRATE_W-1:0]  sym_rate;
  logic [dpmn_pkg::LANES_W-1:0]  lane_count;
  logic [dpmn_pkg::BPP_W-1:0]    pix_depth;

  modport source (
    output valid, pix_clk, sym_rate, lane_count, pix_depth,
    input  ready
  );

  modport sink (
    input  valid, pix_clk, sym_rate, lane_count, pix_depth,
    output ready
  );

endinterface

// ===== rtl/dpmn_result_if.sv =====
// ----------------------------------------------------------------------------
// DisplayPort M/N calculator result channel
// Carries the normalized data M/N and link M/N values of one request.
// ----------------------------------------------------------------------------
interface dpmn_result_if;

  logic                          valid;
  logic                          ready;
  logic [dpmn_pkg::FIELD_W-1:0]  data_m;
  logic [dpmn_pkg::FIELD_W-1:0]  data_n;
  logic [dpmn_pkg::FIELD_W-1:0]  link_m;
  logic [dpmn_pkg::FIELD_W-1:0]  link_n;

  modport source (
    output valid, data_m, data_n, link_m, link_n,
    input  ready
  );

  modport sink (
    input  valid, data_m, data_n, link_m, link_n,
    output ready
  );

endinterface

// ===== rtl/dpmn_div.sv =====
// ----------------------------------------------------------------------------
// DisplayPort M/N restoring divider
// Produces one quotient bit per cycle; a zero divisor gives all ones.
// ----------------------------------------------------------------------------
module dpmn_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dpmn_pkg::NUM_W-1:0]    dividend,
  input  logic [dpmn_pkg::DEN_W-1:0]    divisor,
  output logic [dpmn_pkg::NUM_W-1:0]    quotient,
  output dpmn_pkg::unit_stat_t          stat
);

  logic [dpmn_pkg::NUM_W-1:0] quo;
  logic [dpmn_pkg::DEN_W-1:0] rem;
  logic [dpmn_pkg::DEN_W-1:0] den;
  logic [dpmn_pkg::CNT_W-1:0] count;
  logic                       done;

  logic [dpmn_pkg::DEN_W:0]   trial;
  logic [dpmn_pkg::DEN_W:0]   diff;
  logic                       fits;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem, quo[dpmn_pkg::NUM_W-1]};
    diff  = trial - {1'b0, den};
    fits  = (trial >= {1'b0, den});
  end

  // Control: iteration count and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count <= dpmn_pkg::CNT_W'(dpmn_pkg::NUM_W);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - 1'b1;
      done  <= (count == dpmn_pkg::CNT_W'(1));
    end else begin
      done  <= 1'b0;
    end
  end

  // Datapath: the quotient shifts in from the bottom as the dividend leaves.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (count != '0) begin
      quo <= {quo[dpmn_pkg::NUM_W-2:0], fits};
      if (fits) begin
        rem <= diff[dpmn_pkg::DEN_W-1:0];
      end else begin
        rem <= trial[dpmn_pkg::DEN_W-1:0];
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = (count != '0);
  assign stat.done = done;

endmodule

// ===== rtl/dpmn_norm.sv =====
// ----------------------------------------------------------------------------
// DisplayPort M/N pair normalizer
// Shifts an M/N pair right together, one bit per cycle, until both fit.
// ----------------------------------------------------------------------------
module dpmn_norm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dpmn_pkg::NUM_W-1:0]    m_init,
  input  logic [dpmn_pkg::N_W-1:0]      n_init,
  output logic [dpmn_pkg::FIELD_W-1:0]  m_out,
  output logic [dpmn_pkg::FIELD_W-1:0]  n_out,
  output dpmn_pkg::unit_stat_t          stat
);

  logic [dpmn_pkg::NUM_W-1:0] m;
  logic [dpmn_pkg::N_W-1:0]   n;
  logic                       busy;
  logic                       done;
  logic                       over;

  // Either value still has bits above the result field.
  assign over = (m[dpmn_pkg::NUM_W-1:dpmn_pkg::FIELD_W] != '0) ||
                (n[dpmn_pkg::N_W-1:dpmn_pkg::FIELD_W] != '0);

  // Control: run until the pair fits, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && !over) begin
      busy <= 1'b0;
      done <= 1'b1;
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: shift both values right together.
  always_ff @(posedge clk) begin
    if (start) begin
      m <= m_init;
      n <= n_init;
    end else if (busy && over) begin
      m <= m >> 1;
      n <= n >> 1;
    end
  end

  assign m_out     = m[dpmn_pkg::FIELD_W-1:0];
  assign n_out     = n[dpmn_pkg::FIELD_W-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/dp_link_m_n_calc.sv =====
// ----------------------------------------------------------------------------
// DisplayPort M/N calculator
// Computes the data M/N and link M/N values of a mode on shared units.
// ----------------------------------------------------------------------------
// The block takes one mode request at a time and returns one result per
// request. Data M is bits per pixel * stream * 2^27 / (link * lanes * 8) with
// data N at 2^27, and link M is stream * 2^19 / link with link N at 2^19,
// where stream and link are ten times the pixel clock and the link rate. Each
// pair is shifted right together until both values fit in 24 bits. A zero link
// rate gives M = 0xFFFFFF and N = 0 for both pairs, and a zero lane count for
// the data pair. The one restoring divider is used twice, for the data quotient
// and then the link quotient, and the one-bit-per-cycle normalizing shifter
// then shifts each pair, at least 4 times for the data pair and at most 34
// times for either. A finished result waits in the output register while the
// next request is accepted.
// ----------------------------------------------------------------------------
module dp_link_m_n_calc (
  input  logic             clk,
  input  logic             rst,
  dpmn_mode_if.sink        mode,
  dpmn_result_if.source    result
);

  dpmn_pkg::state_t state;
  dpmn_pkg::state_t state_next;

  // Operands captured and scaled at acceptance.
  logic [dpmn_pkg::STRM_W-1:0]  strm;
  logic [dpmn_pkg::LCLK_W-1:0]  lclk;
  logic [dpmn_pkg::BPP_W-1:0]   bpp;
  logic [dpmn_pkg::LANES_W-1:0] lanes;

  // Products of the data pair.
  logic [dpmn_pkg::PROD_W-1:0]  num_data;
  logic [dpmn_pkg::DEN_W-1:0]   den_data;

  // Normalized data pair, held while the link pair is worked out.
  logic [dpmn_pkg::FIELD_W-1:0] dm_q;
  logic [dpmn_pkg::FIELD_W-1:0] dn_q;

  // Output register.
  logic                         res_valid;
  logic [dpmn_pkg::FIELD_W-1:0] res_dm;
  logic [dpmn_pkg::FIELD_W-1:0] res_dn;
  logic [dpmn_pkg::FIELD_W-1:0] res_lm;
  logic [dpmn_pkg::FIELD_W-1:0] res_ln;

  // Sequencer outputs.
  logic mode_ready;
  logic div_start;
  logic norm_start;
  logic sel_link;
  logic save_data;
  logic res_load;

  // Shared unit connections.
  logic [dpmn_pkg::NUM_W-1:0]   div_dividend;
  logic [dpmn_pkg::DEN_W-1:0]   div_divisor;
  logic [dpmn_pkg::NUM_W-1:0]   div_quotient;
  dpmn_pkg::unit_stat_t         div_stat;
  logic [dpmn_pkg::N_W-1:0]     norm_n_init;
  logic [dpmn_pkg::FIELD_W-1:0] norm_m;
  logic [dpmn_pkg::FIELD_W-1:0] norm_n;
  dpmn_pkg::unit_stat_t         norm_stat;

  logic mode_acc;
  logic res_free;

  assign mode_acc = mode.valid && mode_ready;
  assign res_free = !res_valid || result.ready;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpmn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      dpmn_pkg::ST_IDLE: begin
        if (mode.valid) state_next = dpmn_pkg::ST_PROD;
      end
      dpmn_pkg::ST_PROD:    state_next = dpmn_pkg::ST_LOAD_DD;
      dpmn_pkg::ST_LOAD_DD: state_next = dpmn_pkg::ST_WAIT_DD;
      dpmn_pkg::ST_WAIT_DD: begin
        if (div_stat.done) state_next = dpmn_pkg::ST_LOAD_ND;
      end
      dpmn_pkg::ST_LOAD_ND: state_next = dpmn_pkg::ST_WAIT_ND;
      dpmn_pkg::ST_WAIT_ND: begin
        if (norm_stat.done) state_next = dpmn_pkg::ST_LOAD_DL;
      end
      dpmn_pkg::ST_LOAD_DL: state_next = dpmn_pkg::ST_WAIT_DL;
      dpmn_pkg::ST_WAIT_DL: begin
        if (div_stat.done) state_next = dpmn_pkg::ST_LOAD_NL;
      end
      dpmn_pkg::ST_LOAD_NL: state_next = dpmn_pkg::ST_WAIT_NL;
      dpmn_pkg::ST_WAIT_NL: begin
        if (norm_stat.done) state_next = dpmn_pkg::ST_DONE;
      end
      dpmn_pkg::ST_DONE: begin
        if (res_free) state_next = dpmn_pkg::ST_IDLE;
      end
      default: state_next = dpmn_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    mode_ready = 1'b0;
    div_start  = 1'b0;
    norm_start = 1'b0;
    sel_link   = 1'b0;
    save_data  = 1'b0;
    res_load   = 1'b0;
    case (state)
      dpmn_pkg::ST_IDLE:    mode_ready = 1'b1;
      dpmn_pkg::ST_LOAD_DD: div_start  = 1'b1;
      dpmn_pkg::ST_LOAD_ND: norm_start = 1'b1;
      dpmn_pkg::ST_WAIT_ND: save_data  = norm_stat.done;
      dpmn_pkg::ST_LOAD_DL: begin
        div_start = 1'b1;
        sel_link  = 1'b1;
      end
      dpmn_pkg::ST_WAIT_DL: sel_link = 1'b1;
      dpmn_pkg::ST_LOAD_NL: begin
        norm_start = 1'b1;
        sel_link   = 1'b1;
      end
      dpmn_pkg::ST_WAIT_NL: sel_link = 1'b1;
      dpmn_pkg::ST_DONE:    res_load = res_free;
      default: begin
        mode_ready = 1'b0;
      end
    endcase
  end

  // Capture the request and scale both clocks by ten.
  always_ff @(posedge clk) begin
    if (mode_acc) begin
      strm  <= dpmn_pkg::STRM_W'(mode.pix_clk) * dpmn_pkg::CLOCK_SCALE;
      lclk  <= dpmn_pkg::LCLK_W'(dpmn_pkg::STRM_W'(mode.sym_rate) *
                                 dpmn_pkg::CLOCK_SCALE);
      bpp   <= mode.pix_depth;
      lanes <= mode.lane_count;
    end
  end

  // Products of the data pair; the factor of eight is a shift.
  always_ff @(posedge clk) begin
    if (state == dpmn_pkg::ST_PROD) begin
      num_data <= dpmn_pkg::PROD_W'(bpp) * dpmn_pkg::PROD_W'(strm);
      den_data <= {(dpmn_pkg::DEN_W-3)'(lclk) * (dpmn_pkg::DEN_W-3)'(lanes), 3'b000};
    end
  end

  // Operand selection for the shared units.
  always_comb begin
    if (sel_link) begin
      div_dividend = dpmn_pkg::NUM_W'({strm, {dpmn_pkg::LINK_N_SHIFT{1'b0}}});
      div_divisor  = dpmn_pkg::DEN_W'(lclk);
      norm_n_init  = dpmn_pkg::LINK_N_BASE;
    end else begin
      div_dividend = {num_data, {dpmn_pkg::DATA_N_SHIFT{1'b0}}};
      div_divisor  = den_data;
      norm_n_init  = dpmn_pkg::DATA_N_BASE;
    end
  end

  dpmn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  dpmn_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .start  (norm_start),
    .m_init (div_quotient),
    .n_init (norm_n_init),
    .m_out  (norm_m),
    .n_out  (norm_n),
    .stat   (norm_stat)
  );

  // Hold the normalized data pair.
  always_ff @(posedge clk) begin
    if (save_data) begin
      dm_q <= norm_m;
      dn_q <= norm_n;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_dm <= dm_q;
      res_dn <= dn_q;
      res_lm <= norm_m;
      res_ln <= norm_n;
    end
  end

  assign mode.ready    = mode_ready;
  assign result.valid  = res_valid;
  assign result.data_m = res_dm;
  assign result.data_n = res_dn;
  assign result.link_m = res_lm;
  assign result.link_n = res_ln;

`ifndef SYNTHESIS
  // A request is only taken while both shared units are quiet.
  a_ready_units_idle: assert property (@(posedge clk) disable iff (rst)
    mode_ready |-> (!div_stat.busy && !norm_stat.busy))
    else $error("mode ready while a shared unit is busy");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == dpmn_pkg::ST_WAIT_DD || state == dpmn_pkg::ST_WAIT_DL))
    else $error("divider finished outside a wait state");

  // The normalizer only finishes while the sequencer waits for it.
  a_norm_done_waited: assert property (@(posedge clk) disable iff (rst)
    norm_stat.done |-> (state == dpmn_pkg::ST_WAIT_ND || state == dpmn_pkg::ST_WAIT_NL))
    else $error("normalizer finished outside a wait state");

  // A new result only appears after the link pair is finished.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == dpmn_pkg::ST_DONE))
    else $error("result raised outside the done state");
`endif

endmodule
